FILE: rtl/core/fsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsr_pkg
// Shared types and constants of the Newton-Raphson single-precision square root.
// -----------------------------------------------------------------------------
package fsr_pkg;

  localparam int unsigned CountW = 5;
  localparam int unsigned DivSteps = 25;
  localparam int unsigned StepW = 5;

  localparam logic [7:0]  ExpBias = 8'd127;
  localparam logic [7:0]  ExpAllOnes = 8'hFF;
  localparam logic [31:0] QuietNan = 32'h7FC0_0000;

  // Significand of 1/sqrt2 truncated to 53 bits, exponent -1.
  localparam logic [52:0] InvSqrt2Mant = 53'h16A09E667F3BCC;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_LO,
    CMD_MUL_HI,
    CMD_MUL_SUM,
    CMD_MUL_RND,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_DIV_RND,
    CMD_ADD_ALN,
    CMD_ADD_RND,
    CMD_PUBLISH
  } fsr_cmd_e;

  typedef struct packed {
    fsr_cmd_e cmd;
  } fsr_ctrl_t;

  typedef struct packed {
    logic special;
    logic odd_exp;
    logic div_last;
    logic go_on;
  } fsr_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/fsr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsr_in_if / fsr_out_if
// Valid/ready channels carrying the operand word and the result word.
// -----------------------------------------------------------------------------
interface fsr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_bits;

  modport source (output valid, output operand_bits, input ready);
  modport sink (input valid, input operand_bits, output ready);
endinterface

interface fsr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] root_bits;
  logic [4:0]  iteration_count;

  modport source (output valid, output root_bits, output iteration_count, input ready);
  modport sink (input valid, input root_bits, input iteration_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fsr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsr_datapath
// Operand classification, seed build, 1/sqrt2 multiply, radix-2 divider,
// adder with exponent halving, and the result register.
// -----------------------------------------------------------------------------
module fsr_datapath
  import fsr_pkg::*;
#(
  parameter int unsigned MAX_ITERATIONS = 8
) (
  input  wire logic                clk_i,
  input  wire fsr_ctrl_t           ctrl_i,
  input  wire logic [31:0]         operand_i,
  output fsr_stat_t                stat_o,
  output logic      [31:0]         root_o,
  output logic      [CountW-1:0]   count_o
);

  localparam logic [26:0] CLow = InvSqrt2Mant[26:0];
  localparam logic [25:0] CHigh = InvSqrt2Mant[52:27];
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_ITERATIONS);

  logic [31:0]       a_q, x0_q, x1_q, q_q, res_q;
  logic [CountW-1:0] cnt_q, rcnt_q;
  logic              special_q, odd_q;
  logic [50:0]       lo_q;
  logic [49:0]       hi_q;
  logic [76:0]       p_q;
  logic [25:0]       rem_q;
  logic [24:0]       quo_q;
  logic signed [9:0] qexp_q;
  logic [StepW-1:0]  step_q;
  logic [26:0]       big_q, small_q;
  logic [7:0]        aexp_q;

  // Operand classification and seed.
  logic              in_sign;
  logic [7:0]        in_exp;
  logic [22:0]       in_frac;
  logic signed [9:0] in_e, in_half;
  logic              in_odd;
  logic [7:0]        seed_exp;
  logic              in_special;
  logic [31:0]       in_spec_root;

  always_comb begin
    in_sign  = operand_i[31];
    in_exp   = operand_i[30:23];
    in_frac  = operand_i[22:0];
    in_e     = $signed({2'b00, in_exp}) - $signed({2'b00, ExpBias});
    in_odd   = in_e[0];
    in_half  = (in_e + $signed({9'd0, in_odd})) >>> 1;
    seed_exp = 8'(in_half) + ExpBias;

    in_special = (in_exp == 8'd0) || (in_exp == ExpAllOnes) || in_sign;
    if (in_exp == 8'd0) begin
      in_spec_root = {in_sign, 31'd0};
    end else if (in_exp == ExpAllOnes && in_frac != 23'd0) begin
      in_spec_root = operand_i;
    end else if (in_sign) begin
      in_spec_root = QuietNan;
    end else begin
      in_spec_root = operand_i;
    end
  end

  // Rounding of the 1/sqrt2 product: to binary64, then to binary32.
  logic [76:0] m_norm;
  logic [52:0] m_d53, m_dr;
  logic [53:0] m_d54;
  logic        m_up1, m_up2, m_inc1;
  logic [24:0] m_m25;
  logic [22:0] m_frac;
  logic [7:0]  m_exp;

  always_comb begin
    m_norm = p_q[76] ? p_q : {p_q[75:0], 1'b0};
    m_d53  = m_norm[76:24];
    m_up1  = m_norm[23] & ((|m_norm[22:0]) | m_d53[0]);
    m_d54  = {1'b0, m_d53} + {53'd0, m_up1};
    m_inc1 = m_d54[53];
    m_dr   = m_inc1 ? {1'b1, 52'd0} : m_d54[52:0];
    m_up2  = m_dr[28] & ((|m_dr[27:0]) | m_dr[29]);
    m_m25  = {1'b0, m_dr[52:29]} + {24'd0, m_up2};
    m_frac = m_m25[24] ? 23'd0 : m_m25[22:0];
    m_exp  = x1_q[30:23] - {7'd0, ~p_q[76]} + {7'd0, m_inc1} + {7'd0, m_m25[24]};
  end

  // Divider setup and step.
  logic [23:0] d_ma, d_mb, d_div;
  logic        d_lt, d_ge;
  logic [25:0] d_sub;
  logic [23:0] d_m;
  logic        d_up;
  logic [24:0] d_m25;
  logic [9:0]  d_exp;

  always_comb begin
    d_ma  = {1'b1, a_q[22:0]};
    d_mb  = {1'b1, x1_q[22:0]};
    d_lt  = d_ma < d_mb;
    d_div = {1'b1, x0_q[22:0]};
    d_ge  = rem_q >= {2'b00, d_div};
    d_sub = rem_q - {2'b00, d_div};
    d_m   = quo_q[24:1];
    d_up  = quo_q[0] & ((|rem_q) | d_m[0]);
    d_m25 = {1'b0, d_m} + {24'd0, d_up};
    d_exp = 10'(qexp_q) + {9'd0, d_m25[24]};
  end

  // Adder alignment and rounding.
  logic        x_big;
  logic [31:0] a_bg, a_sm;
  logic [7:0]  a_dist;
  logic [26:0] a_smm, a_sh, a_mask;
  logic        a_lost;
  logic [27:0] a_sum;
  logic [23:0] a_m;
  logic        a_g, a_s, a_up;
  logic [24:0] a_m25;
  logic [7:0]  a_exp;

  always_comb begin
    x_big  = x0_q >= q_q;
    a_bg   = x_big ? x0_q : q_q;
    a_sm   = x_big ? q_q : x0_q;
    a_dist = a_bg[30:23] - a_sm[30:23];
    a_smm  = {1'b1, a_sm[22:0], 3'b000};
    a_sh   = a_smm >> a_dist;
    a_mask = (27'd1 << a_dist) - 27'd1;
    a_lost = |(a_smm & a_mask);

    a_sum = {1'b0, big_q} + {1'b0, small_q};
    if (a_sum[27]) begin
      a_m = a_sum[27:4];
      a_g = a_sum[3];
      a_s = |a_sum[2:0];
    end else begin
      a_m = a_sum[26:3];
      a_g = a_sum[2];
      a_s = |a_sum[1:0];
    end
    a_up  = a_g & (a_s | a_m[0]);
    a_m25 = {1'b0, a_m} + {24'd0, a_up};
    // The trailing decrement halves the sum; it wraps like the 8-bit field.
    a_exp = aexp_q + {7'd0, a_sum[27]} + {7'd0, a_m25[24]} - 8'd1;
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_LOAD: begin
        a_q       <= operand_i;
        cnt_q     <= '0;
        odd_q     <= in_odd;
        special_q <= in_special;
        // A special value is carried in the estimate register to the publish step.
        x1_q      <= in_special ? in_spec_root : {1'b0, seed_exp, 1'b0, in_frac[22:1]};
      end
      CMD_MUL_LO: lo_q <= 51'({1'b1, x1_q[22:0]}) * 51'(CLow);
      CMD_MUL_HI: hi_q <= 50'({1'b1, x1_q[22:0]}) * 50'(CHigh);
      CMD_MUL_SUM: p_q <= {hi_q, 27'd0} + {26'd0, lo_q};
      CMD_MUL_RND: x1_q <= {1'b0, m_exp, m_frac};
      CMD_DIV_INIT: begin
        x0_q   <= x1_q;
        rem_q  <= d_lt ? {1'b0, d_ma, 1'b0} : {2'b00, d_ma};
        qexp_q <= $signed({2'b00, a_q[30:23]}) - $signed({2'b00, x1_q[30:23]})
                  + $signed({2'b00, ExpBias}) - $signed({9'd0, d_lt});
        quo_q  <= '0;
        step_q <= '0;
      end
      CMD_DIV_STEP: begin
        quo_q  <= {quo_q[23:0], d_ge};
        rem_q  <= d_ge ? {d_sub[24:0], 1'b0} : {rem_q[24:0], 1'b0};
        step_q <= step_q + StepW'(1);
      end
      CMD_DIV_RND: q_q <= {1'b0, d_exp[7:0], d_m25[24] ? 23'd0 : d_m25[22:0]};
      CMD_ADD_ALN: begin
        big_q   <= {1'b1, a_bg[22:0], 3'b000};
        small_q <= (a_dist >= 8'd27) ? 27'd1 : {a_sh[26:1], a_sh[0] | a_lost};
        aexp_q  <= a_bg[30:23];
      end
      CMD_ADD_RND: begin
        x1_q  <= {1'b0, a_exp, a_m25[24] ? 23'd0 : a_m25[22:0]};
        cnt_q <= cnt_q + CountW'(1);
      end
      CMD_PUBLISH: begin
        res_q  <= x1_q;
        rcnt_q <= cnt_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.special  = special_q;
    stat_o.odd_exp  = odd_q;
    stat_o.div_last = step_q == StepW'(DivSteps - 1);
    // Both estimates are positive, so their encodings order like the values.
    stat_o.go_on    = (x0_q > x1_q) && (cnt_q < MaxCount);
    root_o          = res_q;
    count_o         = rcnt_q;
  end

endmodule
`default_nettype wire

FILE: rtl/core/fsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fsr_ctrl
// Sequencer: seed, optional 1/sqrt2 multiply, divide/add iterations, publish.
// -----------------------------------------------------------------------------
module fsr_ctrl
  import fsr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire fsr_stat_t stat_i,
  output fsr_ctrl_t      ctrl_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BRANCH,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_MUL_RND,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_RND,
    ST_ADD_ALN,
    ST_ADD_RND,
    ST_CHECK,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   can_publish;

  assign can_publish = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o.cmd = CMD_NONE;
    case (state_q)
      ST_IDLE:     ctrl_o.cmd = in_valid_i ? CMD_LOAD : CMD_NONE;
      ST_MUL_LO:   ctrl_o.cmd = CMD_MUL_LO;
      ST_MUL_HI:   ctrl_o.cmd = CMD_MUL_HI;
      ST_MUL_SUM:  ctrl_o.cmd = CMD_MUL_SUM;
      ST_MUL_RND:  ctrl_o.cmd = CMD_MUL_RND;
      ST_DIV_INIT: ctrl_o.cmd = CMD_DIV_INIT;
      ST_DIV_STEP: ctrl_o.cmd = CMD_DIV_STEP;
      ST_DIV_RND:  ctrl_o.cmd = CMD_DIV_RND;
      ST_ADD_ALN:  ctrl_o.cmd = CMD_ADD_ALN;
      ST_ADD_RND:  ctrl_o.cmd = CMD_ADD_RND;
      ST_DONE:     ctrl_o.cmd = can_publish ? CMD_PUBLISH : CMD_NONE;
      default:     ctrl_o.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_BRANCH;
          end
        end
        ST_BRANCH: begin
          if (stat_i.special) begin
            state_q <= ST_DONE;
          end else if (stat_i.odd_exp) begin
            state_q <= ST_MUL_LO;
          end else begin
            state_q <= ST_DIV_INIT;
          end
        end
        ST_MUL_LO:   state_q <= ST_MUL_HI;
        ST_MUL_HI:   state_q <= ST_MUL_SUM;
        ST_MUL_SUM:  state_q <= ST_MUL_RND;
        ST_MUL_RND:  state_q <= ST_DIV_INIT;
        ST_DIV_INIT: state_q <= ST_DIV_STEP;
        ST_DIV_STEP: begin
          if (stat_i.div_last) begin
            state_q <= ST_DIV_RND;
          end
        end
        ST_DIV_RND:  state_q <= ST_ADD_ALN;
        ST_ADD_ALN:  state_q <= ST_ADD_RND;
        ST_ADD_RND:  state_q <= ST_CHECK;
        ST_CHECK:    state_q <= stat_i.go_on ? ST_DIV_INIT : ST_DONE;
        ST_DONE: begin
          if (can_publish) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default:     state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/float_sqrt_newton_raphson_top.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// float_sqrt_newton_raphson_top
// Single-precision square root refined by Newton-Raphson on a shared unit.
// -----------------------------------------------------------------------------
// The in_i channel takes one word per operand, a raw binary32 encoding; out_o
// returns the root encoding and the number of refinements performed.
// One operand is worked on at a time. A special value (zero, subnormal,
// negative, infinity, NaN) skips refinement and goes straight to publish.
// A normal operand runs N refinements, after a 1/sqrt2 multiply when its
// unbiased exponent is odd; N is at most MAX_ITERATIONS. Each refinement is
// bound by the radix-2 divider, which retires one quotient bit per cycle
// for 25 quotient bits, followed by rounding, the adder's align and round
// steps and the loop test.
// The result word sits in an output register; a new operand is accepted as
// soon as the sequencer is idle, even while that word still waits. If the
// receiver stalls, the next result waits inside until the register frees.
// Reset clears the sequencer and the output valid; no word is pending after.
// -----------------------------------------------------------------------------
module float_sqrt_newton_raphson_top
  import fsr_pkg::*;
#(
  parameter int unsigned MAX_ITERATIONS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fsr_in_if.sink     in_i,
  fsr_out_if.source  out_o
);

  fsr_ctrl_t ctrl;
  fsr_stat_t stat;

  fsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  fsr_datapath #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_datapath (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .operand_i (in_i.operand_bits),
    .stat_o    (stat),
    .root_o    (out_o.root_bits),
    .count_o   (out_o.iteration_count)
  );

  // Only one operand is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("operand accepted while another is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.iteration_count <= CountW'(MAX_ITERATIONS))
    else $error("iteration count beyond the cap");

  // A refined root comes from a positive operand.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.iteration_count != '0 |-> !out_o.root_bits[31])
    else $error("refined root carries a sign");

endmodule
`default_nettype wire
